/* design/blib_pkg.sv */
// Package for the battery level blink indicator.
// Holds the field types, the result struct and the fixed-point constants.
// No dependencies.
package blib_pkg;

    typedef logic [10:0] t_sample;
    typedef logic [9:0]  t_level;
    typedef logic [15:0] t_period;
    typedef logic [15:0] t_thresh;
    typedef logic [25:0] t_avg;

    typedef struct packed {
        logic    led_on;
        logic    beep_on;
        logic    alarm;
        t_level  smoothed_level;
        t_period period_now;
    } t_result;

    localparam int      FRAC_BITS    = 16;
    localparam int      PERIOD_SHIFT = 15;
    localparam logic [15:0] KEEP_WEIGHT = 16'd62259;
    localparam logic [11:0] NEW_WEIGHT  = 12'd3277;
    localparam t_avg    AVG_MAX      = '1;
    localparam t_period PERIOD_RESET = 16'd100;
    localparam t_thresh THRESH_RESET = 16'd846;

endpackage

/* design/blib_if.sv */
// Valid/ready channel interfaces for the blink indicator.
// Sample channel in, status channel out; depends on blib_pkg.
interface blib_sample_if import blib_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface blib_status_if import blib_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    led_on;
    logic    beep_on;
    logic    alarm;
    t_level  smoothed_level;
    t_period period_now;

    modport source (output valid, output led_on, output beep_on, output alarm,
                    output smoothed_level, output period_now, input ready);
    modport sink   (input valid, input led_on, input beep_on, input alarm,
                    input smoothed_level, input period_now, output ready);
endinterface

/* design/blib_avg_filter.sv */
// Exponential average update in unsigned Q10.16.
// Pure combinational; samples at or above SAMPLE_LIMIT leave the average unchanged; depends on blib_pkg.
module blib_avg_filter import blib_pkg::*; #(
    parameter int SAMPLE_LIMIT = 1024
) (
    input  t_avg    i_avg,
    input  t_sample i_sample,
    output t_avg    o_avg
);

    localparam logic [12:0] LIMIT = 13'(SAMPLE_LIMIT);

    logic [41:0] keep_prod;
    logic [22:0] new_prod;
    logic [26:0] sum;
    t_avg        sat;
    logic        take;

    always_comb begin
        keep_prod = 42'(i_avg) * 42'(KEEP_WEIGHT);
        new_prod  = 23'(i_sample) * 23'(NEW_WEIGHT);
        sum       = 27'(keep_prod[41:FRAC_BITS]) + 27'(new_prod);
        sat       = sum[26] ? AVG_MAX : sum[25:0];
        take      = 13'(i_sample) < LIMIT;
        o_avg     = take ? sat : i_avg;
    end

endmodule

/* design/blib_ctrl.sv */
// Indicator state: average, blink counter, periodic threshold check.
// State registers double as the result; uses blib_avg_filter and blib_pkg.
module blib_ctrl import blib_pkg::*; #(
    parameter int CHECK_INTERVAL = 30,
    parameter int MIN_PERIOD     = 5,
    parameter int SAMPLE_LIMIT   = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  logic    i_cfg_we,
    input  t_thresh i_cfg_wdata,
    output t_result o_result
);

    localparam int      CW       = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;
    localparam logic [CW-1:0] CHK_LAST = CW'(CHECK_INTERVAL - 1);
    localparam t_period MIN_P    = 16'(MIN_PERIOD);

    t_avg          r_avg, n_avg;
    t_period       r_count, n_count;
    t_period       r_period, n_period;
    logic          r_alarm, n_alarm;
    logic [CW-1:0] r_check, n_check;
    logic          r_led, n_led;
    logic          r_beep, n_beep;
    t_thresh       r_thresh;

    t_period       cnt_inc;
    logic [32:0]   diff;
    logic [16:0]   per_sum;

    blib_avg_filter #(
        .SAMPLE_LIMIT (SAMPLE_LIMIT)
    ) u_filter (
        .i_avg    (r_avg),
        .i_sample (i_sample),
        .o_avg    (n_avg)
    );

    always_comb begin
        cnt_inc  = r_count + 16'd1;
        n_count  = cnt_inc;
        n_led    = r_led;
        n_beep   = r_beep;
        if (cnt_inc > r_period) begin
            n_count = '0;
            n_led   = 1'b1;
            n_beep  = 1'b0;
        end else if (cnt_inc >= MIN_P) begin
            if (r_alarm) begin
                n_beep = 1'b1;
            end else begin
                n_led = 1'b0;
            end
        end

        diff     = {7'd0, n_avg} - {1'b0, r_thresh, 16'd0};
        per_sum  = 17'(MIN_P) + 17'(diff[25:PERIOD_SHIFT]);
        n_check  = r_check + CW'(1);
        n_alarm  = r_alarm;
        n_period = r_period;
        if (r_check == CHK_LAST) begin
            n_check = '0;
            if (diff[32]) begin
                n_alarm  = 1'b1;
                n_period = MIN_P;
            end else begin
                n_alarm  = 1'b0;
                n_period = per_sum[16] ? 16'hFFFF : per_sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg    <= '0;
            r_count  <= '0;
            r_period <= PERIOD_RESET;
            r_alarm  <= 1'b0;
            r_check  <= '0;
            r_led    <= 1'b0;
            r_beep   <= 1'b0;
            r_thresh <= THRESH_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (i_step) begin
                r_avg    <= n_avg;
                r_count  <= n_count;
                r_period <= n_period;
                r_alarm  <= n_alarm;
                r_check  <= n_check;
                r_led    <= n_led;
                r_beep   <= n_beep;
            end
        end
    end

    assign o_result.led_on         = r_led;
    assign o_result.beep_on        = r_beep;
    assign o_result.alarm          = r_alarm;
    assign o_result.smoothed_level = r_avg[25:FRAC_BITS];
    assign o_result.period_now     = r_period;

endmodule

/* design/battery_level_blink_indicator_unit.sv */
// Top level of the battery level blink indicator.
// Input beat register and handshake; uses blib_ctrl, blib_if and blib_pkg.
//
// One sample beat is taken every clock cycle when the status side keeps up.
// A beat's status appears on the output once it has passed the input register and the state
// registers: while the sample sits in the input register, the average update, blink step and
// threshold check run on it and load the state registers that drive the status beat directly.
// A held status beat stalls the input. The threshold register is written through i_cfg_we /
// i_cfg_wdata; the user must do so only while idle, the block does not enforce it.
module battery_level_blink_indicator_unit import blib_pkg::*; #(
    parameter int CHECK_INTERVAL = 30,
    parameter int MIN_PERIOD     = 5,
    parameter int SAMPLE_LIMIT   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    blib_sample_if.sink          i_in,
    blib_status_if.source        o_out,
    input  logic                 i_cfg_we,
    input  t_thresh              i_cfg_wdata
);

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_out_valid;
    logic    step;
    t_result result;

    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_sample <= i_in.raw_sample;
        end
    end

    blib_ctrl #(
        .CHECK_INTERVAL (CHECK_INTERVAL),
        .MIN_PERIOD     (MIN_PERIOD),
        .SAMPLE_LIMIT   (SAMPLE_LIMIT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (r_in_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.led_on         = result.led_on;
    assign o_out.beep_on        = result.beep_on;
    assign o_out.alarm          = result.alarm;
    assign o_out.smoothed_level = result.smoothed_level;
    assign o_out.period_now     = result.period_now;

endmodule
